// ===== sv/xsrd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package xsrd_pkg;

    // default display size in pixels
    localparam int unsigned DEF_SCREEN_WIDTH  = 64;
    localparam int unsigned DEF_SCREEN_HEIGHT = 32;

    // frame store geometry
    localparam int unsigned STORE_DEPTH  = 256;
    localparam int unsigned STORE_ADDR_W = 8;

    // fixed-point shift used for the wrap-around reciprocals
    localparam int unsigned RECIP_SHIFT = 16;

    // depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // command codes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // input transaction
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [3:0] row_index;
        logic [7:0] sprite_byte;
        logic       first_row;
        logic [7:0] read_address;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic       collision;
        logic [7:0] read_data;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        t_op        op;
        logic       first_row;
        logic [7:0] addr;
        logic [7:0] mask0;
        logic [7:0] mask1;
    } t_cmd;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_RDATA = 2'd1,
        BK_BYTE0 = 2'd2,
        BK_BYTE1 = 2'd3
    } t_back_state;

endpackage
`default_nettype wire

// ===== sv/xor_sprite_row_draw_top.sv =====
// XOR sprite row renderer over a 1-bit-per-pixel frame store of 256 bytes
// (SCREEN_WIDTH x SCREEN_HEIGHT pixels, eight pixels per byte, MSB leftmost).
// Every input transaction yields exactly one output transaction carrying the
// collision flag and, for a read, the addressed byte. A front pipeline of two
// stages wraps the origin, forms the byte address and the two pixel masks,
// then hands the command through a two-entry queue to the back end, which owns
// the frame store with one write port and one registered read port. The back end
// sets the pace and takes a new command only while idle: a draw row steps through
// a read, a read-modify-write of the first byte and a write of the second, a read
// command through a fetch and the data return, and a clear or an unused opcode is
// done in the idle state. Clear and reset empty the store at once through per-byte
// valid bits, so no sweep is needed.
`timescale 1ns / 1ps
`default_nettype none
module xor_sprite_row_draw_top import xsrd_pkg::*; #(
    parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    logic push;
    t_cmd push_cmd;
    logic push_ready;
    logic pop;
    logic pop_valid;
    t_cmd pop_cmd;

    // address and mask preparation
    xsrd_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_push       (push),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    // command queue
    xsrd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd)
    );

    // frame store sequencer
    xsrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_cmd   (pop_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ===== sv/xsrd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xsrd_front import xsrd_pkg::*; #(
    parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_push,
    output t_cmd          o_push_cmd,
    input  wire logic     i_push_ready
);

    localparam int unsigned ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
    localparam logic [16:0] RECIP_X = 17'((1 << RECIP_SHIFT) / SCREEN_WIDTH);
    localparam logic [16:0] RECIP_Y = 17'((1 << RECIP_SHIFT) / SCREEN_HEIGHT);
    localparam logic [8:0]  W9      = 9'(SCREEN_WIDTH);
    localparam logic [8:0]  H9      = 9'(SCREEN_HEIGHT);
    localparam logic [5:0]  RB6     = 6'(ROW_BYTES);

    // stage 1 registers
    logic        r1_v;
    t_in_item    r1_item;
    logic [24:0] r1_px;
    logic [24:0] r1_py;

    // stage 2 registers
    logic        r2_v;
    t_op         r2_op;
    logic        r2_fr;
    logic [7:0]  r2_ra;
    logic [7:0]  r2_sb;
    logic [7:0]  r2_col;
    logic [8:0]  r2_row;
    logic        r2_rok;

    logic        rdy1;
    logic        rdy2;

    // pipeline advance
    assign rdy2       = !r2_v || i_push_ready;
    assign rdy1       = !r1_v || rdy2;
    assign o_in_stall = !rdy1;

    // stage 1: capture transaction and reciprocal products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (rdy1) begin
            r1_v <= i_in_valid;
        end
        if (rdy1 && i_in_valid) begin
            r1_item <= i_in_item;
            r1_px   <= 25'({17'd0, i_in_item.x_pos} * {8'd0, RECIP_X});
            r1_py   <= 25'({17'd0, i_in_item.y_pos} * {8'd0, RECIP_Y});
        end
    end

    // stage 2 logic: remainder with one correction step
    logic [7:0]  qx;
    logic [7:0]  qy;
    logic [16:0] prx;
    logic [16:0] pry;
    logic [16:0] dx;
    logic [16:0] dy;
    logic [8:0]  rx0;
    logic [8:0]  ry0;
    logic [8:0]  rx;
    logic [8:0]  ry;
    logic [8:0]  row_sum;

    always_comb begin
        qx      = r1_px[23:16];
        qy      = r1_py[23:16];
        prx     = 17'({9'd0, qx} * {8'd0, W9});
        pry     = 17'({9'd0, qy} * {8'd0, H9});
        dx      = {9'd0, r1_item.x_pos} - prx;
        dy      = {9'd0, r1_item.y_pos} - pry;
        rx0     = dx[8:0];
        ry0     = dy[8:0];
        rx      = (rx0 >= W9) ? (rx0 - W9) : rx0;
        ry      = (ry0 >= H9) ? (ry0 - H9) : ry0;
        row_sum = ry + {5'd0, r1_item.row_index};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (rdy2) begin
            r2_v <= r1_v;
        end
        if (rdy2 && r1_v) begin
            r2_op  <= t_op'(r1_item.opcode);
            r2_fr  <= r1_item.first_row;
            r2_ra  <= r1_item.read_address;
            r2_sb  <= r1_item.sprite_byte;
            r2_col <= rx[7:0];
            r2_row <= row_sum;
            r2_rok <= (row_sum < H9);
        end
    end

    // stage 3 logic: byte address, clipping and pixel masks
    logic [7:0]  keep;
    logic [7:0]  clip;
    logic [15:0] sh;
    logic [14:0] prod;
    logic [14:0] idx0;
    logic [14:0] idx1;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            keep[7 - b] = (({1'b0, r2_col} + 9'(b)) < W9);
        end
        clip = r2_rok ? (r2_sb & keep) : 8'h00;
        sh   = {clip, 8'h00} >> r2_col[2:0];
        prod = 15'({6'd0, r2_row} * {9'd0, RB6});
        idx0 = prod + {10'd0, r2_col[7:3]};
        idx1 = idx0 + 15'd1;

        o_push_cmd.op        = r2_op;
        o_push_cmd.first_row = r2_fr;
        o_push_cmd.addr      = (r2_op == OP_READ) ? r2_ra : idx0[7:0];
        o_push_cmd.mask0     = (idx0 < 15'(STORE_DEPTH)) ? sh[15:8] : 8'h00;
        o_push_cmd.mask1     = (idx1 < 15'(STORE_DEPTH)) ? sh[7:0] : 8'h00;
    end

    assign o_push = r2_v && i_push_ready;

endmodule
`default_nettype wire

// ===== sv/xsrd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xsrd_queue import xsrd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_push_cmd,
    output logic      o_push_ready,
    input  wire logic i_pop,
    output logic      o_pop_valid,
    output t_cmd      o_pop_cmd
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // status
    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];

    // pointer and fill tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== sv/xsrd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xsrd_back import xsrd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_pop_valid,
    input  wire t_cmd i_pop_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out_item o_out_item
);

    t_back_state r_state;
    t_back_state n_state;
    t_cmd        r_cmd;
    logic        r_flag;
    logic        n_flag;

    // frame store with one valid bit per byte
    logic [7:0]             r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_valid;
    logic [7:0]             r_rdq;
    logic                   r_rdv;

    logic        r_out_v;
    t_out_item   r_out;

    logic        out_free;
    logic        rd_en;
    logic [7:0]  rd_addr;
    logic        wr_en;
    logic [7:0]  wr_addr;
    logic [7:0]  wr_data;
    logic        clr_all;
    logic        out_load;
    t_out_item   out_next;
    logic [7:0]  old_byte;
    logic        hit;

    assign out_free = !r_out_v || !i_out_stall;
    assign old_byte = r_rdv ? r_rdq : 8'h00;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_pop_valid && out_free) begin
                    unique case (i_pop_cmd.op)
                        OP_READ: n_state = BK_RDATA;
                        OP_DRAW: n_state = BK_BYTE0;
                        default: n_state = BK_IDLE;
                    endcase
                end
            end
            BK_RDATA: n_state = BK_IDLE;
            BK_BYTE0: n_state = BK_BYTE1;
            BK_BYTE1: n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_cmd.addr;
        wr_en    = 1'b0;
        wr_addr  = r_cmd.addr;
        wr_data  = 8'h00;
        clr_all  = 1'b0;
        out_load = 1'b0;
        out_next = '{collision: r_flag, read_data: 8'h00};
        hit      = 1'b0;
        n_flag   = r_flag;
        unique case (r_state)
            BK_IDLE: begin
                if (i_pop_valid && out_free) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = i_pop_cmd.addr;
                    unique case (i_pop_cmd.op)
                        OP_CLEAR: begin
                            clr_all  = 1'b1;
                            out_load = 1'b1;
                        end
                        OP_DRAW: begin
                            if (i_pop_cmd.first_row) begin
                                n_flag = 1'b0;
                            end
                        end
                        OP_READ: begin
                            out_load = 1'b0;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_RDATA: begin
                out_load           = 1'b1;
                out_next.read_data = old_byte;
            end
            BK_BYTE0: begin
                hit     = |(old_byte & r_cmd.mask0);
                wr_en   = (r_cmd.mask0 != 8'h00);
                wr_data = old_byte ^ r_cmd.mask0;
                rd_en   = 1'b1;
                rd_addr = r_cmd.addr + 8'd1;
                n_flag  = r_flag | hit;
            end
            BK_BYTE1: begin
                hit                = |(old_byte & r_cmd.mask1);
                wr_en              = (r_cmd.mask1 != 8'h00);
                wr_addr            = r_cmd.addr + 8'd1;
                wr_data            = old_byte ^ r_cmd.mask1;
                n_flag             = r_flag | hit;
                out_load           = 1'b1;
                out_next.collision = r_flag | hit;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_flag  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flag  <= n_flag;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
        if (o_pop) begin
            r_cmd <= i_pop_cmd;
        end
        if (out_load) begin
            r_out <= out_next;
        end
    end

    // byte valid bits, cleared at once by reset or a clear command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // frame store memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdq <= r_mem[rd_addr];
            r_rdv <= r_valid[rd_addr];
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ===== sv/xsrd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xsrd_checker import xsrd_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    // bound on transactions in flight; the block holds at most five at once
    localparam logic [3:0] MAX_INFLIGHT = 4'd6;

    logic       in_acc;
    logic       out_acc;
    logic [3:0] r_cnt;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + 4'd1;
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output transaction changed");

    // no result without an outstanding transaction
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_cnt != 4'd0))
        else $error("output transaction without matching input");

    // occupancy stays within pipeline, queue and back end
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_INFLIGHT)
        else $error("too many transactions in flight");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind xor_sprite_row_draw_top xsrd_checker u_xsrd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire
